/* hw/rtl/assert_macros.svh */
// Assertion helpers included by pixel_blob_box_grouper_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hw/rtl/pbbg_pkg.sv */
package pbbg_pkg;

  localparam int PIX_W     = 8;
  localparam int THR_W     = 16;
  localparam int DIST_W    = 25;
  localparam int FW_W      = 13;
  localparam int GI_W      = 4;
  localparam int OUT_CW    = 12;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_DETECT_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_RED      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_THRESHOLD = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLOB_DISTANCE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd4;

  localparam logic [DIST_W-1:0] RST_BLOB_DISTANCE = 25'd100;
  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH   = 13'd640;

  typedef struct packed {
    logic              detect_mode;
    logic [PIX_W-1:0]  target_red;
    logic [THR_W-1:0]  pixel_threshold;
    logic [DIST_W-1:0] blob_distance;
    logic [FW_W-1:0]   frame_width;
  } cfg_t;

endpackage

/* hw/rtl/pbbg_if.sv */
interface pbbg_in_if;
  import pbbg_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_now;
  logic [PIX_W-1:0] red_prev;
  logic             frame_end;

  modport source (output valid, red_now, red_prev, frame_end, input ready);
  modport sink (input valid, red_now, red_prev, frame_end, output ready);
endinterface

interface pbbg_out_if;
  import pbbg_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_box;
  logic [PIX_W-1:0]  pixel_out;
  logic              hit;
  logic [GI_W-1:0]   group_index;
  logic              opened_new;
  logic              table_full;
  logic [OUT_CW-1:0] box_min_x;
  logic [OUT_CW-1:0] box_min_y;
  logic [OUT_CW-1:0] box_max_x;
  logic [OUT_CW-1:0] box_max_y;
  logic              last;

  modport source (output valid, is_box, pixel_out, hit, group_index, opened_new,
                  table_full, box_min_x, box_min_y, box_max_x, box_max_y, last,
                  input ready);
  modport sink (input valid, is_box, pixel_out, hit, group_index, opened_new,
                table_full, box_min_x, box_min_y, box_max_x, box_max_y, last,
                output ready);
endinterface

/* hw/rtl/pbbg_cfg.sv */
module pbbg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbbg_pkg::CFG_AW-1:0]  paddr,
  input  logic [pbbg_pkg::CFG_DW-1:0]  pwdata,
  output logic [pbbg_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output pbbg_pkg::cfg_t               cfg
);
  import pbbg_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DETECT_MODE:     cfg_nxt.detect_mode     = pwdata[0];
        REG_TARGET_RED:      cfg_nxt.target_red      = pwdata[PIX_W-1:0];
        REG_PIXEL_THRESHOLD: cfg_nxt.pixel_threshold = pwdata[THR_W-1:0];
        REG_BLOB_DISTANCE:   cfg_nxt.blob_distance   = pwdata[DIST_W-1:0];
        REG_FRAME_WIDTH:     cfg_nxt.frame_width     = pwdata[FW_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DETECT_MODE:     prdata = CFG_DW'(cfg_r.detect_mode);
      REG_TARGET_RED:      prdata = CFG_DW'(cfg_r.target_red);
      REG_PIXEL_THRESHOLD: prdata = CFG_DW'(cfg_r.pixel_threshold);
      REG_BLOB_DISTANCE:   prdata = CFG_DW'(cfg_r.blob_distance);
      REG_FRAME_WIDTH:     prdata = CFG_DW'(cfg_r.frame_width);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_mode     <= 1'b0;
      cfg_r.target_red      <= '0;
      cfg_r.pixel_threshold <= '0;
      cfg_r.blob_distance   <= RST_BLOB_DISTANCE;
      cfg_r.frame_width     <= RST_FRAME_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hw/rtl/pbbg_ram.sv */
module pbbg_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pbbg_dist.sv */
// Box match pipeline: read data -> corner squares -> sum, min, compare.
module pbbg_dist #(
  parameter int COORD_BITS = 12,
  parameter int IDX_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          flush,
  input  logic                          issue,
  input  logic [IDX_W-1:0]              issue_idx,
  input  logic [COORD_BITS-1:0]         x,
  input  logic [COORD_BITS-1:0]         y,
  input  logic [pbbg_pkg::DIST_W-1:0]   blob_distance,
  input  logic [4*COORD_BITS-1:0]       rd_box,
  output logic                          res_valid,
  output logic                          res_match,
  output logic [IDX_W-1:0]              res_idx,
  output logic [4*COORD_BITS-1:0]       res_box
);
  import pbbg_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int BOX_W = 4 * C;
  localparam int SQ_W  = 2 * C;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

  function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  logic             a_valid_r, a_valid_nxt;
  logic [IDX_W-1:0] a_idx_r, a_idx_nxt;

  logic             b_valid_r, b_valid_nxt;
  logic [IDX_W-1:0] b_idx_r, b_idx_nxt;
  logic [BOX_W-1:0] b_box_r, b_box_nxt;
  logic [SQ_W-1:0]  b_sq_r [4];
  logic [SQ_W-1:0]  b_sq_nxt [4];

  logic             c_valid_r, c_valid_nxt;
  logic             c_match_r, c_match_nxt;
  logic [IDX_W-1:0] c_idx_r, c_idx_nxt;
  logic [BOX_W-1:0] c_box_r, c_box_nxt;

  logic [C-1:0]     d [4];
  logic [SUM_W-1:0] dl, dr, dm;

  // box layout: {min_x, min_y, max_x, max_y}
  always_comb begin
    d[0] = abs_diff(rd_box[4*C-1:3*C], x);
    d[1] = abs_diff(rd_box[3*C-1:2*C], y);
    d[2] = abs_diff(rd_box[2*C-1:C], x);
    d[3] = abs_diff(rd_box[C-1:0], y);
    for (int k = 0; k < 4; k++) begin
      b_sq_nxt[k] = SQ_W'(d[k]) * SQ_W'(d[k]);
    end
  end

  always_comb begin
    dl = SUM_W'(b_sq_r[0]) + SUM_W'(b_sq_r[1]);
    dr = SUM_W'(b_sq_r[2]) + SUM_W'(b_sq_r[3]);
    dm = (dl < dr) ? dl : dr;
  end

  always_comb begin
    a_valid_nxt = issue && !flush;
    a_idx_nxt   = issue_idx;
    b_valid_nxt = a_valid_r && !flush;
    b_idx_nxt   = a_idx_r;
    b_box_nxt   = rd_box;
    c_valid_nxt = b_valid_r && !flush;
    c_idx_nxt   = b_idx_r;
    c_box_nxt   = b_box_r;
    c_match_nxt = CMP_W'(dm) < CMP_W'(blob_distance);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r   <= a_idx_nxt;
    b_idx_r   <= b_idx_nxt;
    b_box_r   <= b_box_nxt;
    b_sq_r    <= b_sq_nxt;
    c_idx_r   <= c_idx_nxt;
    c_box_r   <= c_box_nxt;
    c_match_r <= c_match_nxt;
  end

  assign res_valid = c_valid_r;
  assign res_match = c_match_r;
  assign res_idx   = c_idx_r;
  assign res_box   = c_box_r;

endmodule

/* hw/rtl/pixel_blob_box_grouper_unit.sv */
// Pixel blob box grouper. Takes one pixel request per item in raster order
// (red of the current and previous frame plus a frame-end mark), tests it
// against the target color or the previous frame, and groups hit pixels into
// up to MAX_BOXES bounding boxes held in a single-port-write, registered-read
// box memory. Every request yields one pixel result first; a frame-end request
// then yields one result per stored box, in creation order, and clears the
// column and row counters. Boxes persist across frames until reset. A pixel
// that misses goes straight to its pixel result, and a hit with no stored box
// opens the first box. A hit that scans stored boxes issues one box read per
// cycle into a three-stage match pipeline; a scan that finds no match ends in
// a new box or the table-full flag. A frame end dumps the stored boxes with
// the memory read and the output load alternating, and a stalled sink holds
// the dump. The box memory has no clearing pass: only entries below the box
// count are ever read. Configuration goes through an APB-style port and is to
// be written only while the block is idle; the user must keep to this, as the
// block itself does not enforce it.
`include "assert_macros.svh"

module pixel_blob_box_grouper_unit #(
  parameter int MAX_BOXES  = 16,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pbbg_in_if.sink                      in_ch,
  pbbg_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbbg_pkg::CFG_AW-1:0]  paddr,
  input  logic [pbbg_pkg::CFG_DW-1:0]  pwdata,
  output logic [pbbg_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import pbbg_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int BOX_W = 4 * C;
  localparam int NX_W  = (C + 1 > FW_W) ? C + 1 : FW_W;
  localparam int SQ_W  = 2 * PIX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_OPEN  = 3'd3;
  localparam logic [2:0] S_PIX   = 3'd4;
  localparam logic [2:0] S_DRD   = 3'd5;
  localparam logic [2:0] S_DOUT  = 3'd6;

  cfg_t cfg;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [C-1:0]     col_r, col_nxt;
  logic [C-1:0]     row_r, row_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             ov_r, ov_nxt;

  // request payload held for the whole item
  logic [PIX_W-1:0] now_r, now_nxt;
  logic [PIX_W-1:0] prev_r, prev_nxt;
  logic             fend_r, fend_nxt;
  logic [C-1:0]     x_r, x_nxt;
  logic [C-1:0]     y_r, y_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] gi_r, gi_nxt;
  logic             opn_r, opn_nxt;
  logic             full_r, full_nxt;

  // output register
  logic              o_is_box_r, o_is_box_nxt;
  logic [PIX_W-1:0]  o_pix_r, o_pix_nxt;
  logic              o_hit_r, o_hit_nxt;
  logic [GI_W-1:0]   o_gi_r, o_gi_nxt;
  logic              o_opn_r, o_opn_nxt;
  logic              o_full_r, o_full_nxt;
  logic [OUT_CW-1:0] o_min_x_r, o_min_x_nxt;
  logic [OUT_CW-1:0] o_min_y_r, o_min_y_nxt;
  logic [OUT_CW-1:0] o_max_x_r, o_max_x_nxt;
  logic [OUT_CW-1:0] o_max_y_r, o_max_y_nxt;
  logic              o_last_r, o_last_nxt;

  // box memory and match pipeline
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [BOX_W-1:0] ram_wdata;
  logic             ram_re;
  logic [BOX_W-1:0] ram_rdata;
  logic             issue;
  logic             flush;
  logic             res_valid;
  logic             res_match;
  logic [IDX_W-1:0] res_idx;
  logic [BOX_W-1:0] res_box;

  logic             accept;
  logic             out_free;
  logic [PIX_W-1:0] ref_val;
  logic [PIX_W-1:0] red_diff;
  logic [SQ_W-1:0]  red_sq;
  logic             hit_c;
  logic [NX_W-1:0]  nx;
  logic [C-1:0]     w_min_x, w_min_y, w_max_x, w_max_y;

  pbbg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbbg_ram #(
    .DEPTH (MAX_BOXES),
    .AW    (IDX_W),
    .DW    (BOX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  pbbg_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .flush         (flush),
    .issue         (issue),
    .issue_idx     (rd_idx_r[IDX_W-1:0]),
    .x             (x_r),
    .y             (y_r),
    .blob_distance (cfg.blob_distance),
    .rd_box        (ram_rdata),
    .res_valid     (res_valid),
    .res_match     (res_match),
    .res_idx       (res_idx),
    .res_box       (res_box)
  );

  // one request in flight at a time; the output register frees the sink side
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;

  // stale box reads left in the pipeline after a match are dropped here
  assign flush = (state_r != S_SCAN);

  // threshold test on the held pixel
  always_comb begin
    ref_val  = cfg.detect_mode ? prev_r : cfg.target_red;
    red_diff = (now_r >= ref_val) ? (now_r - ref_val) : (ref_val - now_r);
    red_sq   = SQ_W'(red_diff) * SQ_W'(red_diff);
    hit_c    = cfg.detect_mode ? (red_sq >= cfg.pixel_threshold)
                               : (red_sq <= cfg.pixel_threshold);
  end

  // matched box widened to take the pixel; layout {min_x, min_y, max_x, max_y}
  always_comb begin
    w_min_x = (x_r < res_box[4*C-1:3*C]) ? x_r : res_box[4*C-1:3*C];
    w_min_y = (y_r < res_box[3*C-1:2*C]) ? y_r : res_box[3*C-1:2*C];
    w_max_x = (x_r > res_box[2*C-1:C])   ? x_r : res_box[2*C-1:C];
    w_max_y = (y_r > res_box[C-1:0])     ? y_r : res_box[C-1:0];
  end

  assign nx = NX_W'(col_r) + NX_W'(1);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    rd_idx_nxt = rd_idx_r;
    ov_nxt     = ov_r;
    now_nxt    = now_r;
    prev_nxt   = prev_r;
    fend_nxt   = fend_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    hit_nxt    = hit_r;
    gi_nxt     = gi_r;
    opn_nxt    = opn_r;
    full_nxt   = full_r;

    o_is_box_nxt = o_is_box_r;
    o_pix_nxt    = o_pix_r;
    o_hit_nxt    = o_hit_r;
    o_gi_nxt     = o_gi_r;
    o_opn_nxt    = o_opn_r;
    o_full_nxt   = o_full_r;
    o_min_x_nxt  = o_min_x_r;
    o_min_y_nxt  = o_min_y_r;
    o_max_x_nxt  = o_max_x_r;
    o_max_y_nxt  = o_max_y_r;
    o_last_nxt   = o_last_r;

    ram_we    = 1'b0;
    ram_waddr = res_idx;
    ram_wdata = {w_min_x, w_min_y, w_max_x, w_max_y};
    ram_re    = 1'b0;
    issue     = 1'b0;

    // drop the held result once the sink takes it
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt  = in_ch.red_now;
          prev_nxt = in_ch.red_prev;
          fend_nxt = in_ch.frame_end;
          x_nxt    = col_r;
          y_nxt    = row_r;
          // advance the raster counters now; the pixel keeps its own x and y
          if (in_ch.frame_end) begin
            col_nxt = '0;
            row_nxt = '0;
          end else if (nx >= NX_W'(cfg.frame_width) || nx[C]) begin
            col_nxt = '0;
            row_nxt = row_r + C'(1);
          end else begin
            col_nxt = nx[C-1:0];
          end
          state_nxt = S_CLASS;
        end
      end

      S_CLASS: begin
        hit_nxt    = hit_c;
        gi_nxt     = '0;
        opn_nxt    = 1'b0;
        full_nxt   = 1'b0;
        rd_idx_nxt = '0;
        if (!hit_c) begin
          state_nxt = S_PIX;
        end else if (cnt_r == '0) begin
          state_nxt = S_OPEN;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one box read per cycle until every stored box is in flight
        if (rd_idx_r < cnt_r) begin
          ram_re     = 1'b1;
          issue      = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        // first match in creation order wins; write back the widened box
        if (res_valid) begin
          if (res_match) begin
            ram_we    = 1'b1;
            gi_nxt    = res_idx;
            state_nxt = S_PIX;
          end else if (CNT_W'(res_idx) == cnt_r - CNT_W'(1)) begin
            state_nxt = S_OPEN;
          end
        end
      end

      S_OPEN: begin
        if (cnt_r < CNT_W'(MAX_BOXES)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[IDX_W-1:0];
          ram_wdata = {x_r, y_r, x_r, y_r};
          gi_nxt    = cnt_r[IDX_W-1:0];
          opn_nxt   = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = S_PIX;
      end

      S_PIX: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_is_box_nxt = 1'b0;
          o_pix_nxt    = hit_r ? PIX_MAX : now_r;
          o_hit_nxt    = hit_r;
          o_gi_nxt     = GI_W'(gi_r);
          o_opn_nxt    = opn_r;
          o_full_nxt   = full_r;
          o_min_x_nxt  = '0;
          o_min_y_nxt  = '0;
          o_max_x_nxt  = '0;
          o_max_y_nxt  = '0;
          o_last_nxt   = !fend_r || (cnt_r == '0);
          rd_idx_nxt   = '0;
          state_nxt    = (fend_r && cnt_r != '0) ? S_DRD : S_IDLE;
        end
      end

      S_DRD: begin
        ram_re    = 1'b1;
        state_nxt = S_DOUT;
      end

      S_DOUT: begin
        // read data holds in the memory output register while the sink stalls
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_is_box_nxt = 1'b1;
          o_pix_nxt    = '0;
          o_hit_nxt    = 1'b0;
          o_gi_nxt     = GI_W'(rd_idx_r);
          o_opn_nxt    = 1'b0;
          o_full_nxt   = 1'b0;
          o_min_x_nxt  = OUT_CW'(ram_rdata[4*C-1:3*C]);
          o_min_y_nxt  = OUT_CW'(ram_rdata[3*C-1:2*C]);
          o_max_x_nxt  = OUT_CW'(ram_rdata[2*C-1:C]);
          o_max_y_nxt  = OUT_CW'(ram_rdata[C-1:0]);
          o_last_nxt   = (rd_idx_r == cnt_r - CNT_W'(1));
          if (rd_idx_r == cnt_r - CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + CNT_W'(1);
            state_nxt  = S_DRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      rd_idx_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rd_idx_r <= rd_idx_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    prev_r     <= prev_nxt;
    fend_r     <= fend_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    hit_r      <= hit_nxt;
    gi_r       <= gi_nxt;
    opn_r      <= opn_nxt;
    full_r     <= full_nxt;
    o_is_box_r <= o_is_box_nxt;
    o_pix_r    <= o_pix_nxt;
    o_hit_r    <= o_hit_nxt;
    o_gi_r     <= o_gi_nxt;
    o_opn_r    <= o_opn_nxt;
    o_full_r   <= o_full_nxt;
    o_min_x_r  <= o_min_x_nxt;
    o_min_y_r  <= o_min_y_nxt;
    o_max_x_r  <= o_max_x_nxt;
    o_max_y_r  <= o_max_y_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.is_box      = o_is_box_r;
  assign out_ch.pixel_out   = o_pix_r;
  assign out_ch.hit         = o_hit_r;
  assign out_ch.group_index = o_gi_r;
  assign out_ch.opened_new  = o_opn_r;
  assign out_ch.table_full  = o_full_r;
  assign out_ch.box_min_x   = o_min_x_r;
  assign out_ch.box_min_y   = o_min_y_r;
  assign out_ch.box_max_x   = o_max_x_r;
  assign out_ch.box_max_y   = o_max_y_r;
  assign out_ch.last        = o_last_r;

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CNT_W'(MAX_BOXES))
  `ASSERT_IMPLIES(a_wr_state, clk, rst_n, ram_we, state_r == S_SCAN || state_r == S_OPEN)
  `ASSERT_NEXT(a_accept_class, clk, rst_n, in_ch.valid && in_ch.ready, state_r == S_CLASS)
  `ASSERT_IMPLIES(a_cnt_step, clk, rst_n, $past(rst_n) && cnt_r != $past(cnt_r), cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule
